// ===== design/ctw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ctw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int CELL_AW    = $clog2(CELL_COUNT);

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h07;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'd10;
  localparam logic [CHAR_W-1:0] BACKSPACE_CODE = 8'd8;

  typedef enum logic [OP_W-1:0] {
    OP_PLAIN = 2'd0,
    OP_COLOR = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_COPY,
    S_DRAIN,
    S_FILL,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // take the input item
    logic exec;        // cursor update, glyph write or read issue
    logic cnt_zero;
    logic cnt_tail;    // sweep counter to the first cell of the bottom row
    logic cnt_inc;
    logic copy_rd;     // scroll copy: read one row below the counter
    logic fill_wr;     // blank the cell at the counter
    logic fill_reset;  // blank with the reset attribute
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic is_clear;
    logic scroll_needed;
    logic copy_last;
    logic fill_last;
    logic out_ok;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/ctw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ctw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ctw_pkg::sts_t sts,
  output ctw_pkg::cmd_t      cmd,
  input  wire logic          in_valid,
  output logic               in_stall
);
  import ctw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (sts.fill_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        priority if (sts.is_read) state_nxt = S_RDWAIT;
        else if (sts.is_clear) state_nxt = S_FILL;
        else if (sts.scroll_needed) state_nxt = S_COPY;
        else if (sts.out_ok) state_nxt = S_IDLE;
        else state_nxt = S_RESULT;
      end
      S_RDWAIT: begin
        state_nxt = sts.out_ok ? S_IDLE : S_RESULT;
      end
      S_COPY: begin
        if (sts.copy_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_FILL;
      end
      S_FILL: begin
        if (sts.fill_last) state_nxt = sts.out_ok ? S_IDLE : S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_INIT: begin
        cmd.fill_wr    = 1'b1;
        cmd.fill_reset = 1'b1;
        cmd.cnt_inc    = 1'b1;
      end
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (sts.is_read) cmd.load_out = 1'b0;
        else if (sts.is_clear || sts.scroll_needed) cmd.cnt_zero = 1'b1;
        else cmd.load_out = sts.out_ok;
      end
      S_RDWAIT: begin
        cmd.load_out = sts.out_ok;
      end
      S_COPY: begin
        cmd.copy_rd  = 1'b1;
        cmd.cnt_inc  = !sts.copy_last;
        cmd.cnt_tail = sts.copy_last;
      end
      S_DRAIN: begin
        cmd = '0;
      end
      S_FILL: begin
        cmd.fill_wr  = 1'b1;
        cmd.cnt_inc  = 1'b1;
        cmd.load_out = sts.fill_last && sts.out_ok;
      end
      S_RESULT: begin
        cmd.load_out = sts.out_ok;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ctw_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ctw_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ctw_pkg::cmd_t                 cmd,
  output ctw_pkg::sts_t                      sts,
  input  wire logic [ctw_pkg::OP_W-1:0]      in_op,
  input  wire logic [ctw_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [ctw_pkg::ATTR_W-1:0]    in_attribute,
  input  wire logic [ctw_pkg::IDX_W-1:0]     in_cell_index,
  input  wire logic                          cfg_valid,
  input  wire logic [ctw_pkg::ATTR_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ctw_pkg::COL_W-1:0]          out_cursor_col,
  output logic [ctw_pkg::ROW_W-1:0]          out_cursor_row,
  output logic                               out_scrolled,
  output logic [ctw_pkg::CHAR_W-1:0]         out_read_char,
  output logic [ctw_pkg::ATTR_W-1:0]         out_read_attr
);
  import ctw_pkg::*;

  logic [CELL_W-1:0] mem [0:CELL_COUNT-1];

  op_t               op_r;
  logic [CHAR_W-1:0] char_r;
  logic [ATTR_W-1:0] attr_r;
  logic [IDX_W-1:0]  idx_r;
  logic [ATTR_W-1:0] def_attr_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              scroll_r;
  logic              hit_r;
  logic [CELL_AW-1:0] cnt_r;
  logic [CELL_W-1:0] rd_data_r;
  logic              pend_vld_r;
  logic [CELL_AW-1:0] pend_addr_r;
  logic              out_valid_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_scr_r;
  logic [CHAR_W-1:0] out_char_r;
  logic [ATTR_W-1:0] out_attr_r;

  logic is_text, is_nl, is_bs, is_glyph, wrap, last_row, line_adv, hit;
  logic [CELL_AW-1:0] pos;
  logic [ATTR_W-1:0]  glyph_attr;
  logic               mem_we, rd_en;
  logic [CELL_AW-1:0] mem_waddr, rd_addr;
  logic [CELL_W-1:0]  mem_wdata;

  // item decode against the current cursor
  always_comb begin
    is_text    = (op_r == OP_PLAIN) || (op_r == OP_COLOR);
    is_nl      = is_text && (char_r == NEWLINE_CODE);
    is_bs      = (op_r == OP_PLAIN) && (char_r == BACKSPACE_CODE);
    is_glyph   = is_text && !is_nl && !is_bs;
    wrap       = col_r == COL_W'(COLUMNS - 1);
    last_row   = row_r == ROW_W'(ROWS - 1);
    line_adv   = is_nl || (is_glyph && wrap);
    hit        = idx_r < IDX_W'(CELL_COUNT);
    pos        = CELL_AW'(row_r) * CELL_AW'(COLUMNS) + CELL_AW'(col_r);
    glyph_attr = (op_r == OP_PLAIN) ? def_attr_r : attr_r;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    priority if (op_r == OP_CLEAR) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (line_adv) begin
      col_nxt = '0;
      if (!last_row) row_nxt = row_r + ROW_W'(1);
    end else if (is_bs) begin
      if (col_r != '0) col_nxt = col_r - COL_W'(1);
    end else if (is_glyph) begin
      col_nxt = col_r + COL_W'(1);
    end else begin
      col_nxt = col_r;
    end
  end

  always_comb begin
    sts.is_read       = op_r == OP_READ;
    sts.is_clear      = op_r == OP_CLEAR;
    sts.scroll_needed = line_adv && last_row;
    sts.copy_last     = cnt_r == CELL_AW'(CELL_COUNT - COLUMNS - 1);
    sts.fill_last     = cnt_r == CELL_AW'(CELL_COUNT - 1);
    sts.out_ok        = !out_valid_r || !out_stall;
  end

  // one write port: pending scroll copy, blank fill or glyph
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = {glyph_attr, char_r};
    priority if (pend_vld_r) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = rd_data_r;
    end else if (cmd.fill_wr) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r;
      mem_wdata = {(cmd.fill_reset ? RESET_ATTR : def_attr_r), BLANK_CHAR};
    end else if (cmd.exec && is_glyph) begin
      mem_we = 1'b1;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_comb begin
    rd_en   = cmd.copy_rd || (cmd.exec && (op_r == OP_READ) && hit);
    rd_addr = cmd.copy_rd ? cnt_r + CELL_AW'(COLUMNS) : CELL_AW'(idx_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_op);
      char_r <= in_char_code;
      attr_r <= in_attribute;
      idx_r  <= in_cell_index;
    end
    if (cmd.exec) begin
      hit_r    <= hit;
      scroll_r <= line_adv && last_row;
    end
    pend_addr_r <= cnt_r;
    if (cmd.load_out) begin
      // a result loaded in the exec cycle takes the cursor being written now
      out_col_r  <= cmd.exec ? col_nxt : col_r;
      out_row_r  <= cmd.exec ? row_nxt : row_r;
      out_scr_r  <= cmd.exec ? (line_adv && last_row) : scroll_r;
      out_char_r <= (op_r == OP_READ && hit_r) ? rd_data_r[CHAR_W-1:0] : '0;
      out_attr_r <= (op_r == OP_READ && hit_r) ? rd_data_r[CELL_W-1:CHAR_W] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_attr_r  <= RESET_ATTR;
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) def_attr_r <= cfg_data;
      if (cmd.exec) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      priority if (cmd.cnt_zero) cnt_r <= '0;
      else if (cmd.cnt_tail) cnt_r <= CELL_AW'(CELL_COUNT - COLUMNS);
      else if (cmd.cnt_inc) cnt_r <= cnt_r + CELL_AW'(1);
      else cnt_r <= cnt_r;
      // copy data lands in the cycle after its read
      pend_vld_r <= cmd.copy_rd;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_scrolled   = out_scr_r;
  assign out_read_char  = out_char_r;
  assign out_read_attr  = out_attr_r;

endmodule
`default_nettype wire

// ===== design/text_console_writer_top.sv =====
// Text console writer: an 80x25 store of character/attribute cells in a single
// memory with one write and one registered read port, plus a cursor. One item is
// worked at a time, and its result sits in an output register so the next item
// can be taken while it waits. A step that scrolls walks the memory: it copies
// the 1920 cells below the top row up one row, drains the last copy write,
// then blanks the 80 cells of the bottom row with the default attribute, the
// single memory port moving one cell a cycle. Clear blanks all 2000 cells.
// After reset a clearing pass blanks the store with attribute 0x07; in_stall
// stays high during it, while cfg writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [ctw_pkg::OP_W-1:0]    in_op,
  input  wire logic [ctw_pkg::CHAR_W-1:0]  in_char_code,
  input  wire logic [ctw_pkg::ATTR_W-1:0]  in_attribute,
  input  wire logic [ctw_pkg::IDX_W-1:0]   in_cell_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ctw_pkg::COL_W-1:0]        out_cursor_col,
  output logic [ctw_pkg::ROW_W-1:0]        out_cursor_row,
  output logic                             out_scrolled,
  output logic [ctw_pkg::CHAR_W-1:0]       out_read_char,
  output logic [ctw_pkg::ATTR_W-1:0]       out_read_attr,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ctw_pkg::ATTR_W-1:0]  cfg_data
);
  import ctw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ctw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_valid (in_valid),
    .in_stall (in_stall)
  );

  ctw_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_char_code   (in_char_code),
    .in_attribute   (in_attribute),
    .in_cell_index  (in_cell_index),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_scrolled   (out_scrolled),
    .out_read_char  (out_read_char),
    .out_read_attr  (out_read_attr)
  );

endmodule
`default_nettype wire

// ===== dv/text_console_writer_top_tb.sv =====
`timescale 1ns / 1ps
module text_console_writer_top_tb;
  import ctw_pkg::*;

  localparam int WATCHDOG_LIMIT = 25000;
  localparam int SETTLE_CYCLES  = 2100;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 112;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic [IDX_W-1:0]  idx;
  } console_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scrolled;
    logic [CHAR_W-1:0] rd_char;
    logic [ATTR_W-1:0] rd_attr;
  } cursor_report_t;

  typedef struct packed {
    console_cmd_t   cmd;
    logic           pinned;
    cursor_report_t report;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_op = '0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [ATTR_W-1:0] in_attribute = '0;
  logic [IDX_W-1:0]  in_cell_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [COL_W-1:0]  out_cursor_col;
  logic [ROW_W-1:0]  out_cursor_row;
  logic              out_scrolled;
  logic [CHAR_W-1:0] out_read_char;
  logic [ATTR_W-1:0] out_read_attr;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data = '0;

  // shadow copy of the console
  logic [CELL_W-1:0] screen [CELL_COUNT];
  int                cur_c;
  int                cur_r;
  logic [ATTR_W-1:0] fill_attr;
  cursor_report_t    pending_q [$];

  int fail_count;
  int shown;
  int idle_cycles;
  int items_sent;
  int scroll_count;
  int read_count;
  int clear_count;
  int attr_writes;
  int gap_pct;
  int stall_pct;
  int hold_left;

  text_console_writer_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_char_code   (in_char_code),
    .in_attribute   (in_attribute),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_scrolled   (out_scrolled),
    .out_read_char  (out_read_char),
    .out_read_attr  (out_read_attr),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit advance_line();
    cur_c = 0;
    if (cur_r + 1 < ROWS) begin
      cur_r++;
      return 1'b0;
    end
    // bottom row reached: shift everything up one row
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = {fill_attr, BLANK_CHAR};
    return 1'b1;
  endfunction

  function automatic bit place_glyph(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr);
    screen[cur_r * COLUMNS + cur_c] = {attr, ch};
    cur_c++;
    if (cur_c >= COLUMNS) return advance_line();
    return 1'b0;
  endfunction

  function automatic cursor_report_t console_step(console_cmd_t c);
    cursor_report_t r;
    r = '0;
    case (c.op)
      OP_PLAIN: begin
        if (c.ch == NEWLINE_CODE) r.scrolled = advance_line();
        else if (c.ch == BACKSPACE_CODE) begin
          if (cur_c > 0) cur_c--;
        end else r.scrolled = place_glyph(c.ch, fill_attr);
      end
      OP_COLOR: begin
        // backspace is an ordinary glyph here
        if (c.ch == NEWLINE_CODE) r.scrolled = advance_line();
        else r.scrolled = place_glyph(c.ch, c.attr);
      end
      OP_CLEAR: begin
        foreach (screen[i]) screen[i] = {fill_attr, BLANK_CHAR};
        cur_c = 0;
        cur_r = 0;
      end
      default: begin
        if (c.idx < CELL_COUNT) {r.rd_attr, r.rd_char} = screen[c.idx];
      end
    endcase
    r.col = cur_c[COL_W-1:0];
    r.row = cur_r[ROW_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t plan_row(op_t op, logic [CHAR_W-1:0] ch,
                                         logic [ATTR_W-1:0] attr, logic [IDX_W-1:0] idx,
                                         logic pinned, int col, int row,
                                         logic [CHAR_W-1:0] rd_char,
                                         logic [ATTR_W-1:0] rd_attr);
    plan_row_t p;
    p.cmd.op = op;
    p.cmd.ch = ch;
    p.cmd.attr = attr;
    p.cmd.idx = idx;
    p.pinned = pinned;
    p.report.col = col[COL_W-1:0];
    p.report.row = row[ROW_W-1:0];
    p.report.scrolled = 1'b0;
    p.report.rd_char = rd_char;
    p.report.rd_attr = rd_attr;
    return p;
  endfunction

  function automatic console_cmd_t random_cmd(int nl_pct);
    console_cmd_t c;
    int pick;
    c.op = $urandom_range(0, 1) ? OP_COLOR : OP_PLAIN;
    c.ch = CHAR_W'($urandom_range(0, 255));
    c.attr = ATTR_W'($urandom_range(0, 255));
    c.idx = IDX_W'($urandom_range(0, 2**IDX_W - 1));
    pick = $urandom_range(0, 99);
    if (pick < nl_pct) begin
      c.op = ($urandom_range(0, 3) == 0) ? OP_COLOR : OP_PLAIN;
      c.ch = NEWLINE_CODE;
    end else if (pick < nl_pct + 5) begin
      c.op = OP_PLAIN;
      c.ch = BACKSPACE_CODE;
    end else if (pick < nl_pct + 8) begin
      c.op = OP_COLOR;
      c.ch = BACKSPACE_CODE;
    end else if (pick < nl_pct + 23) begin
      c.op = OP_READ;
      case ($urandom_range(0, 6))
        0: c.idx = IDX_W'($urandom_range(CELL_COUNT, 2**IDX_W - 1));
        1, 2, 3: c.idx = IDX_W'(cur_r * COLUMNS + int'($urandom_range(0, COLUMNS - 1)));
        default: c.idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
      endcase
    end else if ($urandom_range(0, 299) == 0) begin
      c.op = OP_CLEAR;
    end
    return c;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_cmd(input console_cmd_t c, input logic pinned,
                          input cursor_report_t pinned_rep);
    cursor_report_t want;
    in_valid <= 1'b1;
    in_op <= c.op;
    in_char_code <= c.ch;
    in_attribute <= c.attr;
    in_cell_index <= c.idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = console_step(c);
    pending_q.push_back(pinned ? pinned_rep : want);
    items_sent++;
    scroll_count += want.scrolled;
    if (c.op == OP_READ) read_count++;
    if (c.op == OP_CLEAR) clear_count++;
    @(negedge clk);
    if ($urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_fill_attr(input logic [ATTR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fill_attr = v;
    attr_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if ($urandom_range(1, 100) <= stall_pct) begin
      hold_left = $urandom_range(1, 8);
    end
    out_stall <= (hold_left > 0);
  end

  always @(posedge clk) begin : check_results
    cursor_report_t got;
    cursor_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_cursor_col, out_cursor_row, out_scrolled, out_read_char, out_read_attr};
      if (pending_q.size() == 0) begin
        fail_count++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: col %0d row %0d scrolled %0d char 0x%02h attr 0x%02h",
                   got.col, got.row, got.scrolled, got.rd_char, got.rd_attr);
        end
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("mismatch at %0t: col %0d/%0d row %0d/%0d scrolled %0d/%0d", $realtime,
                     want.col, got.col, want.row, got.row, want.scrolled, got.scrolled);
            $display("  char 0x%02h/0x%02h attr 0x%02h/0x%02h (expected/actual)",
                     want.rd_char, got.rd_char, want.rd_attr, got.rd_attr);
          end
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_q.size());
      $display("text_console_writer_top_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t plan [$];
    foreach (screen[i]) screen[i] = {RESET_ATTR, BLANK_CHAR};
    fill_attr = RESET_ATTR;
    gap_pct = 25;
    stall_pct = 25;

    // pinned rows: expected cursor/read values are obvious from the reset state
    plan.push_back(plan_row(OP_READ, 8'h00, 8'h00, 11'd0, 1'b1, 0, 0, BLANK_CHAR, RESET_ATTR));
    plan.push_back(plan_row(OP_READ, 8'hFF, 8'hFF, 11'd1999, 1'b1, 0, 0,
                            BLANK_CHAR, RESET_ATTR));
    plan.push_back(plan_row(OP_READ, 8'h41, 8'h00, 11'd2000, 1'b1, 0, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_READ, 8'h00, 8'h00, 11'd2047, 1'b1, 0, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_PLAIN, BACKSPACE_CODE, 8'hFF, 11'd2047, 1'b1, 0, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_PLAIN, 8'h41, 8'hFF, 11'd0, 1'b1, 1, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_PLAIN, 8'h00, 8'h00, 11'd0, 1'b1, 2, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_PLAIN, 8'hFF, 8'h00, 11'd0, 1'b1, 3, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_READ, 8'h00, 8'h00, 11'd0, 1'b1, 3, 0, 8'h41, RESET_ATTR));
    plan.push_back(plan_row(OP_READ, 8'h00, 8'h00, 11'd1, 1'b1, 3, 0, 8'h00, RESET_ATTR));
    plan.push_back(plan_row(OP_PLAIN, BACKSPACE_CODE, 8'h00, 11'd0, 1'b1, 2, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_COLOR, BACKSPACE_CODE, 8'hA5, 11'd0, 1'b0, 0, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_READ, 8'h00, 8'h00, 11'd2, 1'b0, 0, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_COLOR, NEWLINE_CODE, 8'h5A, 11'd5, 1'b1, 0, 1, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_PLAIN, NEWLINE_CODE, 8'h00, 11'd0, 1'b1, 0, 2, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_COLOR, 8'hFF, 8'hFF, 11'd0, 1'b0, 0, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_COLOR, 8'h00, 8'h00, 11'd2047, 1'b0, 0, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_READ, 8'h00, 8'h00, 11'd160, 1'b0, 0, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_READ, 8'h00, 8'h00, 11'd161, 1'b0, 0, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_PLAIN, 8'h7E, 8'h00, 11'd2047, 1'b0, 0, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_CLEAR, NEWLINE_CODE, 8'hFF, 11'h555, 1'b1, 0, 0, 8'h00, 8'h00));
    plan.push_back(plan_row(OP_READ, 8'h00, 8'h00, 11'd2, 1'b1, 0, 0, BLANK_CHAR, RESET_ATTR));
    plan.push_back(plan_row(OP_READ, 8'hFF, 8'hFF, 11'h2AA, 1'b1, 0, 0,
                            BLANK_CHAR, RESET_ATTR));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_cmd(plan[i].cmd, plan[i].pinned, plan[i].report);

    for (int p = 0; p < PHASES; p++) begin
      drain_pending();
      case (p)
        0: set_fill_attr(8'h00);
        1: set_fill_attr(8'hFF);
        PHASES - 1: set_fill_attr(RESET_ATTR);
        default: set_fill_attr(ATTR_W'($urandom_range(0, 255)));
      endcase
      if (p == PHASES - 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      // a clear now and then so blank fill is seen with the new attribute
      if (p % 3 == 2)
        send_cmd(console_cmd_t'({OP_CLEAR, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047))}), 1'b0, '0);
      // even phases are newline heavy to reach the bottom and scroll,
      // odd ones run long lines that wrap
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_cmd(random_cmd((p % 2 == 0) ? 14 : 2), 1'b0, '0);
    end

    drain_pending();
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += pending_q.size();

    $display("covered %0d items: %0d reads, %0d clears, %0d scrolling steps",
             items_sent, read_count, clear_count, scroll_count);
    $display("default attribute written %0d times, %0d failed checks", attr_writes, fail_count);
    if (fail_count == 0)
      $display("text_console_writer_top_tb OK");
    else
      $display("text_console_writer_top_tb NOT OK");
    $finish;
  end

endmodule
